/* sv/ray_box_nearest_hit_macros.svh */
// Assertion macros shared by the ray/box checker.
`ifndef RAY_BOX_NEAREST_HIT_MACROS_SVH
`define RAY_BOX_NEAREST_HIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBNH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rbnh_pkg.sv */
// Shared types and constants of the ray/box nearest-hit block.
package rbnh_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COORD_W       = 32;
    localparam int DIR_W         = 18;
    localparam int ENT_W         = 16;
    localparam int DIST_W        = 31;
    localparam int CFG_IDX_W     = 3;

    // Magnitude below which an axis is treated as parallel (0.0001, rounded).
    localparam logic [DIR_W-1:0] EPS_Q =
        DIR_W'(((1 << FRACTION_BITS) + 5000) / 10000);

    localparam logic signed [COORD_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] DIST_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = 18'sd65536;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
        logic [ENT_W-1:0]          entity_id;
        logic                      last_box;
    } box_item_t;

    typedef struct packed {
        logic              box_hit;
        logic [DIST_W-1:0] hit_distance;
        logic              best_valid;
        logic [ENT_W-1:0]  best_entity;
        logic [DIST_W-1:0] best_distance;
        logic              set_done;
    } box_result_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W:0]   num;
        logic signed [DIR_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [DIST_W-1:0] tmin;
    } slab_rsp_t;

endpackage

/* sv/rbnh_div.sv */
// Shared radix-2 restoring divider: saturated (num << FRACTION_BITS) / den.
module rbnh_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  rbnh_pkg::div_req_t  req,
    output rbnh_pkg::div_rsp_t  rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [17:0] ud_reg, ud_next;
    logic [17:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] q_reg, q_next;

    logic [32:0] num_abs;
    logic [17:0] den_abs;
    logic [63:0] n_wide;
    logic        ovf_w;
    logic [18:0] cand;
    logic [18:0] cand_sub;
    logic        ge;
    logic signed [31:0] quot;

    always_comb begin
        num_abs  = req.num[32] ? 33'(-req.num) : 33'(req.num);
        den_abs  = req.den[17] ? 18'(-req.den) : 18'(req.den);
        n_wide   = {31'b0, num_abs} << rbnh_pkg::FRACTION_BITS;
        // Quotient reaches 2^32 exactly when the top half is not below the divisor.
        ovf_w    = n_wide[63:32] >= {14'b0, den_abs};
        cand     = {rem_reg, low_reg[31]};
        cand_sub = cand - {1'b0, ud_reg};
        ge       = cand >= {1'b0, ud_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        ud_next   = ud_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (req.start) begin
            busy_next = !ovf_w;
            done_next = ovf_w;
            neg_next  = req.num[32] ^ req.den[17];
            ovf_next  = ovf_w;
            cnt_next  = 5'd31;
            ud_next   = den_abs;
            rem_next  = n_wide[49:32];
            low_next  = n_wide[31:0];
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next = ge ? cand_sub[17:0] : cand[17:0];
            q_next   = {q_reg[30:0], ge};
            low_next = {low_reg[30:0], 1'b0};
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        ud_reg  <= ud_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    // Saturate to the signed 32-bit range.
    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || (q_reg > 32'h8000_0000)) begin
                quot = rbnh_pkg::DIST_MIN;
            end else begin
                quot = -$signed(q_reg);
            end
        end else begin
            if (ovf_reg || q_reg[31]) begin
                quot = rbnh_pkg::DIST_MAX;
            end else begin
                quot = $signed(q_reg);
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot;

endmodule

/* sv/rbnh_slab.sv */
// Slab-test sequencer: walks the three axes through the shared divider.
module rbnh_slab (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  rbnh_pkg::box_item_t        box,
    input  logic signed [31:0]         origin_x,
    input  logic signed [31:0]         origin_y,
    input  logic signed [31:0]         origin_z,
    input  logic signed [17:0]         dir_x,
    input  logic signed [17:0]         dir_y,
    input  logic signed [17:0]         dir_z,
    input  logic                       ack,
    output rbnh_pkg::slab_rsp_t        rsp,
    output rbnh_pkg::div_req_t         div_req,
    input  rbnh_pkg::div_rsp_t         div_rsp
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_AXIS   = 3'd1;
    localparam logic [2:0] ST_DIV_LO = 3'd2;
    localparam logic [2:0] ST_DIV_HI = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;
    localparam logic [2:0] ST_NARROW = 3'd5;
    localparam logic [2:0] ST_CHECK  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          axis_reg, axis_next;
    logic                hit_reg, hit_next;
    logic signed [31:0]  tmin_reg, tmin_next;
    logic signed [31:0]  tmax_reg, tmax_next;
    logic signed [31:0]  t1_reg, t1_next;
    logic signed [31:0]  t2_reg, t2_next;
    rbnh_pkg::box_item_t box_reg, box_next;

    logic signed [31:0]  org;
    logic signed [17:0]  dir;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    logic [17:0]         mag;
    logic                parallel;
    logic                outside;
    logic signed [32:0]  num_lo;
    logic signed [32:0]  num_hi;

    always_comb begin
        unique case (axis_reg)
            2'd0: begin
                org = origin_x;
                dir = dir_x;
                lo  = box_reg.box_min_x;
                hi  = box_reg.box_max_x;
            end
            2'd1: begin
                org = origin_y;
                dir = dir_y;
                lo  = box_reg.box_min_y;
                hi  = box_reg.box_max_y;
            end
            default: begin
                org = origin_z;
                dir = dir_z;
                lo  = box_reg.box_min_z;
                hi  = box_reg.box_max_z;
            end
        endcase
        mag      = dir[17] ? 18'(-dir) : 18'(dir);
        parallel = mag < rbnh_pkg::EPS_Q;
        outside  = (org < lo) || (org > hi);
        num_lo   = 33'(lo) - 33'(org);
        num_hi   = 33'(hi) - 33'(org);
    end

    always_comb begin
        div_req.start = ((state_reg == ST_AXIS) && !parallel) ||
                        ((state_reg == ST_DIV_LO) && div_rsp.done);
        div_req.num   = (state_reg == ST_AXIS) ? num_lo : num_hi;
        div_req.den   = dir;
    end

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        hit_next   = hit_reg;
        tmin_next  = tmin_reg;
        tmax_next  = tmax_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        box_next   = box_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    box_next   = box;
                    axis_next  = 2'd0;
                    hit_next   = 1'b1;
                    tmin_next  = '0;
                    tmax_next  = rbnh_pkg::DIST_MAX;
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS: begin
                if (parallel) begin
                    if (outside) begin
                        hit_next   = 1'b0;
                        state_next = ST_DONE;
                    end else if (axis_reg == AXIS_LAST) begin
                        state_next = ST_DONE;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end else begin
                    state_next = ST_DIV_LO;
                end
            end
            ST_DIV_LO: begin
                if (div_rsp.done) begin
                    t1_next    = div_rsp.quot;
                    state_next = ST_DIV_HI;
                end
            end
            ST_DIV_HI: begin
                if (div_rsp.done) begin
                    t2_next    = div_rsp.quot;
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER: begin
                if (t1_reg > t2_reg) begin
                    t1_next = t2_reg;
                    t2_next = t1_reg;
                end
                state_next = ST_NARROW;
            end
            ST_NARROW: begin
                if (t1_reg > tmin_reg) begin
                    tmin_next = t1_reg;
                end
                if (t2_reg < tmax_reg) begin
                    tmax_next = t2_reg;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (tmin_reg > tmax_reg) begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (axis_reg == AXIS_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_AXIS;
                end
            end
            ST_DONE: begin
                // Hold the verdict until the top level takes it.
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        axis_reg <= axis_next;
        hit_reg  <= hit_next;
        tmin_reg <= tmin_next;
        tmax_reg <= tmax_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        box_reg  <= box_next;
    end

    assign rsp.done = (state_reg == ST_DONE);
    assign rsp.hit  = hit_reg;
    assign rsp.tmin = tmin_reg[30:0];

endmodule

/* sv/ray_box_nearest_hit.sv */
// Top level of the ray/box nearest-hit block: ray registers, best tracker, output stage.
//
// Usage: write the ray (origin_x/y/z, dir_x/y/z at indexes 0..5) through the
// cfg_wr_en/cfg_index/cfg_wdata port while no box is in flight; writes to
// other indexes are dropped. Then stream boxes on s_valid/s_ready; each box
// gives exactly one transaction on m_valid/m_ready with its own hit verdict
// and the nearest hit of the current set. A box with last_box set closes the
// set: its result carries the final best, and the tracker clears afterwards.
// Each axis with a non-negligible direction takes two passes through the
// single shared divider plus ordering, narrowing and check steps; a
// near-parallel axis skips the divider, and a pass whose quotient reaches
// 2^32 or more skips the bit steps. A miss on an earlier axis ends the
// walk there. One box is in flight at a time; s_ready rises together
// with m_valid, so no new box is taken until the last result is
// registered. The output register holds the result while the receiver
// stalls; the next box still runs and then waits until that register
// empties. Reset (aresetn low, synchronous) restores the ray to the origin
// looking along +z and clears the nearest-hit state and both channels.
module ray_box_nearest_hit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rbnh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rbnh_pkg::box_item_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rbnh_pkg::box_result_t                m_data
);

    logic signed [31:0] origin_x_reg, origin_x_next;
    logic signed [31:0] origin_y_reg, origin_y_next;
    logic signed [31:0] origin_z_reg, origin_z_next;
    logic signed [17:0] dir_x_reg, dir_x_next;
    logic signed [17:0] dir_y_reg, dir_y_next;
    logic signed [17:0] dir_z_reg, dir_z_next;

    logic                          busy_reg, busy_next;
    logic [rbnh_pkg::ENT_W-1:0]    ent_reg, ent_next;
    logic                          last_reg, last_next;
    logic                          best_valid_reg, best_valid_next;
    logic [rbnh_pkg::ENT_W-1:0]    best_ent_reg, best_ent_next;
    logic [rbnh_pkg::DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic                          m_valid_reg, m_valid_next;
    rbnh_pkg::box_result_t         m_data_reg, m_data_next;

    logic                          accept;
    logic                          ack;
    logic                          upd;
    logic                          new_valid;
    logic [rbnh_pkg::ENT_W-1:0]    new_ent;
    logic [rbnh_pkg::DIST_W-1:0]   new_dist;

    rbnh_pkg::slab_rsp_t           slab_rsp;
    rbnh_pkg::div_req_t            div_req;
    rbnh_pkg::div_rsp_t            div_rsp;

    assign accept = s_valid && s_ready;
    assign ack    = slab_rsp.done && (!m_valid_reg || m_ready);

    rbnh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rbnh_slab u_slab (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .box      (s_data),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .origin_z (origin_z_reg),
        .dir_x    (dir_x_reg),
        .dir_y    (dir_y_reg),
        .dir_z    (dir_z_reg),
        .ack      (ack),
        .rsp      (slab_rsp),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    // Ray registers.
    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        origin_z_next = origin_z_reg;
        dir_x_next    = dir_x_reg;
        dir_y_next    = dir_y_reg;
        dir_z_next    = dir_z_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rbnh_pkg::REG_ORIGIN_X: origin_x_next = $signed(cfg_wdata);
                rbnh_pkg::REG_ORIGIN_Y: origin_y_next = $signed(cfg_wdata);
                rbnh_pkg::REG_ORIGIN_Z: origin_z_next = $signed(cfg_wdata);
                rbnh_pkg::REG_DIR_X:    dir_x_next    = $signed(cfg_wdata[17:0]);
                rbnh_pkg::REG_DIR_Y:    dir_y_next    = $signed(cfg_wdata[17:0]);
                rbnh_pkg::REG_DIR_Z:    dir_z_next    = $signed(cfg_wdata[17:0]);
                default: begin
                end
            endcase
        end
    end

    // Nearest-hit update and result assembly.
    always_comb begin
        upd       = slab_rsp.hit && (!best_valid_reg || (slab_rsp.tmin < best_dist_reg));
        new_valid = best_valid_reg || slab_rsp.hit;
        new_ent   = upd ? ent_reg : best_ent_reg;
        new_dist  = upd ? slab_rsp.tmin : best_dist_reg;

        m_data_next.box_hit       = slab_rsp.hit;
        m_data_next.hit_distance  = slab_rsp.hit ? slab_rsp.tmin : '0;
        m_data_next.best_valid    = new_valid;
        m_data_next.best_entity   = new_ent;
        m_data_next.best_distance = new_dist;
        m_data_next.set_done      = last_reg;

        busy_next       = busy_reg;
        ent_next        = ent_reg;
        last_next       = last_reg;
        best_valid_next = best_valid_reg;
        best_ent_next   = best_ent_reg;
        best_dist_next  = best_dist_reg;
        m_valid_next    = m_valid_reg;

        if (accept) begin
            busy_next = 1'b1;
            ent_next  = s_data.entity_id;
            last_next = s_data.last_box;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (ack) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            if (last_reg) begin
                best_valid_next = 1'b0;
                best_ent_next   = '0;
                best_dist_next  = rbnh_pkg::DIST_W'(rbnh_pkg::DIST_MAX);
            end else begin
                best_valid_next = new_valid;
                best_ent_next   = new_ent;
                best_dist_next  = new_dist;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            dir_x_reg      <= '0;
            dir_y_reg      <= '0;
            dir_z_reg      <= rbnh_pkg::DIR_Z_RESET;
            busy_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
            best_ent_reg   <= '0;
            best_dist_reg  <= rbnh_pkg::DIST_W'(rbnh_pkg::DIST_MAX);
            m_valid_reg    <= 1'b0;
        end else begin
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            origin_z_reg   <= origin_z_next;
            dir_x_reg      <= dir_x_next;
            dir_y_reg      <= dir_y_next;
            dir_z_reg      <= dir_z_next;
            busy_reg       <= busy_next;
            best_valid_reg <= best_valid_next;
            best_ent_reg   <= best_ent_next;
            best_dist_reg  <= best_dist_next;
            m_valid_reg    <= m_valid_next;
        end
        ent_reg  <= ent_next;
        last_reg <= last_next;
        if (ack) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/rbnh_checker.sv */
// Port-level checker for the ray/box nearest-hit block, bound to the top level.
`include "ray_box_nearest_hit_macros.svh"

module rbnh_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input rbnh_pkg::box_result_t m_data
);

    `RBNH_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    `RBNH_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second box taken while busy")

    `RBNH_ASSERT_SAME(a_miss_zero, m_valid && !m_data.box_hit, m_data.hit_distance == '0, "miss with nonzero distance")

    `RBNH_ASSERT_SAME(a_best_le_hit, m_valid && m_data.box_hit, m_data.best_valid && (m_data.best_distance <= m_data.hit_distance), "best worse than current hit")

    `RBNH_ASSERT_SAME(a_no_best_clear, m_valid && !m_data.best_valid, (m_data.best_entity == '0) && (m_data.best_distance == rbnh_pkg::DIST_W'(rbnh_pkg::DIST_MAX)), "empty best not at reset value")

endmodule

bind ray_box_nearest_hit rbnh_checker u_rbnh_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the ray/box slab test with nearest-hit tracking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rbnh_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rbnh_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint ONE          = 65536;
    localparam longint COORD_TOP    = 64'sd2147483647;
    localparam longint COORD_BOTTOM = -64'sd2147483648;
    localparam int     RANDOM_BOXES = 450;
    localparam int     DRAIN_CYCLES = 250;
    localparam int     CYCLE_LIMIT  = 700000;

    class nearest_hit_scoreboard;
        logic signed [rbnh_pkg::COORD_W-1:0] ray_origin[3];
        logic signed [rbnh_pkg::DIR_W-1:0]   ray_dir[3];
        logic [rbnh_pkg::DIST_W-1:0]         near_dist;
        logic [rbnh_pkg::ENT_W-1:0]          near_ent;
        bit                                  near_valid;
        rbnh_pkg::box_result_t               expected_q[$];
        int                                  failures;

        function new();
            ray_origin = '{0, 0, 0};
            ray_dir    = '{0, 0, rbnh_pkg::DIR_Z_RESET};
            clear_nearest();
            failures = 0;
        endfunction

        function void clear_nearest();
            near_dist  = '1;
            near_ent   = '0;
            near_valid = 1'b0;
        endfunction

        function void set_ray_reg(logic [rbnh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                rbnh_pkg::REG_ORIGIN_X: ray_origin[0] = data;
                rbnh_pkg::REG_ORIGIN_Y: ray_origin[1] = data;
                rbnh_pkg::REG_ORIGIN_Z: ray_origin[2] = data;
                rbnh_pkg::REG_DIR_X:    ray_dir[0] = data[rbnh_pkg::DIR_W-1:0];
                rbnh_pkg::REG_DIR_Y:    ray_dir[1] = data[rbnh_pkg::DIR_W-1:0];
                rbnh_pkg::REG_DIR_Z:    ray_dir[2] = data[rbnh_pkg::DIR_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact quotient, truncated toward zero, saturated to 32 bits signed.
        function longint slab_distance(longint num, longint den);
            bit     neg;
            longint un;
            longint ud;
            longint q;
            neg = (num < 0) != (den < 0);
            un  = (num < 0) ? -num : num;
            ud  = (den < 0) ? -den : den;
            q   = (un << rbnh_pkg::FRACTION_BITS) / ud;
            if (neg) begin
                return (q > 64'sd2147483648) ? COORD_BOTTOM : -q;
            end
            return (q > COORD_TOP) ? COORD_TOP : q;
        endfunction

        function void note_box(rbnh_pkg::box_item_t b);
            longint                lo[3];
            longint                hi[3];
            longint                o;
            longint                d;
            longint                mag;
            longint                t1;
            longint                t2;
            longint                swap_t;
            longint                tmin;
            longint                tmax;
            bit                    hit;
            rbnh_pkg::box_result_t r;
            lo   = '{b.box_min_x, b.box_min_y, b.box_min_z};
            hi   = '{b.box_max_x, b.box_max_y, b.box_max_z};
            tmin = 0;
            tmax = COORD_TOP;
            hit  = 1'b1;
            for (int a = 0; a < 3 && hit; a++) begin
                o   = ray_origin[a];
                d   = ray_dir[a];
                mag = (d < 0) ? -d : d;
                if (mag < longint'(rbnh_pkg::EPS_Q)) begin
                    // near-parallel axis: origin must sit inside the slab
                    if (o < lo[a] || o > hi[a]) hit = 1'b0;
                end else begin
                    t1 = slab_distance(lo[a] - o, d);
                    t2 = slab_distance(hi[a] - o, d);
                    if (t1 > t2) begin
                        swap_t = t1;
                        t1 = t2;
                        t2 = swap_t;
                    end
                    if (t1 > tmin) tmin = t1;
                    if (t2 < tmax) tmax = t2;
                    if (tmin > tmax) hit = 1'b0;
                end
            end
            // ties keep the earlier box
            if (hit && (!near_valid || tmin < longint'(near_dist))) begin
                near_dist  = rbnh_pkg::DIST_W'(tmin);
                near_ent   = b.entity_id;
                near_valid = 1'b1;
            end
            r.box_hit       = hit;
            r.hit_distance  = hit ? rbnh_pkg::DIST_W'(tmin) : '0;
            r.best_valid    = near_valid;
            r.best_entity   = near_ent;
            r.best_distance = near_dist;
            r.set_done      = b.last_box;
            expected_q = {expected_q, r};
            if (b.last_box) clear_nearest();
        endfunction

        function void compare_field(string field, logic [63:0] want_v, logic [63:0] got_v);
            if (want_v !== got_v) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            end
        endfunction

        function void check_result(rbnh_pkg::box_result_t got);
            rbnh_pkg::box_result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("result with nothing pending: %p", got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("box_hit", want.box_hit, got.box_hit);
            compare_field("hit_distance", want.hit_distance, got.hit_distance);
            compare_field("best_valid", want.best_valid, got.best_valid);
            compare_field("best_entity", want.best_entity, got.best_entity);
            compare_field("best_distance", want.best_distance, got.best_distance);
            compare_field("set_done", want.set_done, got.set_done);
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [rbnh_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [31:0]                      cfg_wdata;
    logic                             s_valid;
    logic                             s_ready;
    rbnh_pkg::box_item_t              s_data;
    logic                             m_valid;
    logic                             m_ready;
    rbnh_pkg::box_result_t            m_data;

    nearest_hit_scoreboard  hits;
    bit                     src_idle_en;
    bit                     sink_idle_en;
    int                     cycle_count;

    ray_box_nearest_hit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint clamp_coord(longint v);
        if (v > COORD_TOP) return COORD_TOP;
        if (v < COORD_BOTTOM) return COORD_BOTTOM;
        return v;
    endfunction

    function automatic rbnh_pkg::box_item_t make_box(longint x0, longint y0, longint z0,
                                                     longint x1, longint y1, longint z1,
                                                     logic [rbnh_pkg::ENT_W-1:0] ent,
                                                     logic last);
        rbnh_pkg::box_item_t b;
        b.box_min_x = x0;
        b.box_min_y = y0;
        b.box_min_z = z0;
        b.box_max_x = x1;
        b.box_max_y = y1;
        b.box_max_z = z1;
        b.entity_id = ent;
        b.last_box  = last;
        return b;
    endfunction

    // Box placed around a point on the current ray, sometimes behind it or inverted.
    function automatic rbnh_pkg::box_item_t aimed_box();
        longint t;
        longint c;
        longint e;
        longint lo[3];
        longint hi[3];
        longint swap_v;
        t = longint'($urandom_range(0, 4194304));
        if ($urandom_range(0, 7) == 0) t = t - 4194304;
        for (int a = 0; a < 3; a++) begin
            c = longint'(hits.ray_origin[a])
                + ((t * longint'(hits.ray_dir[a])) >>> rbnh_pkg::FRACTION_BITS);
            e = ($urandom_range(0, 9) == 0) ? 0 : longint'($urandom_range(0, 262144));
            lo[a] = clamp_coord(c - e);
            hi[a] = clamp_coord(c + e);
            if ($urandom_range(0, 19) == 0) begin
                swap_v = lo[a];
                lo[a]  = hi[a];
                hi[a]  = swap_v;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                        rbnh_pkg::ENT_W'($urandom), $urandom_range(0, 5) == 0);
    endfunction

    function automatic rbnh_pkg::box_item_t noise_box();
        rbnh_pkg::box_item_t b;
        b.box_min_x = $urandom;
        b.box_min_y = $urandom;
        b.box_min_z = $urandom;
        b.box_max_x = $urandom;
        b.box_max_y = $urandom;
        b.box_max_z = $urandom;
        b.entity_id = rbnh_pkg::ENT_W'($urandom);
        b.last_box  = ($urandom_range(0, 5) == 0);
        return b;
    endfunction

    function automatic logic [31:0] pick_origin();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endfunction

    // Upper bits carry junk; only the low DIR_W bits are meaningful.
    function automatic logic [31:0] pick_dir();
        logic [31:0] junk;
        int          pick;
        junk = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 2) return {junk[31:rbnh_pkg::DIR_W], {rbnh_pkg::DIR_W{1'b0}}};
        if (pick < 4)
            return {junk[31:rbnh_pkg::DIR_W], rbnh_pkg::DIR_W'($urandom_range(0, 20) - 10)};
        if (pick < 5) return junk;
        return {junk[31:rbnh_pkg::DIR_W], rbnh_pkg::DIR_W'($urandom_range(0, 131072) - 65536)};
    endfunction

    task automatic write_reg(logic [rbnh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        hits.set_ray_reg(idx, data);
    endtask

    task automatic send_box(rbnh_pkg::box_item_t b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        hits.note_box(b);
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic close_phase();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (hits.expected_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_idle_en ? $urandom_range(0, 5) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            hits.check_result(m_data);
        end
    end

    initial begin
        int random_sent;
        int n;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        random_sent  = 0;
        hits = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset ray: origin at zero, looking along +z
        send_box(make_box(-ONE, -ONE, 2*ONE, ONE, ONE, 3*ONE, 16'd1, 1'b0));
        send_box(make_box(-ONE, -ONE, 2*ONE, ONE, ONE, 3*ONE, 16'd2, 1'b0));
        send_box(make_box(-ONE, -ONE, ONE, ONE, ONE, 4*ONE, 16'hFFFF, 1'b0));
        send_box(make_box(2*ONE, -ONE, ONE, 3*ONE, ONE, 2*ONE, 16'd3, 1'b0));
        send_box(make_box(ONE, -ONE, ONE, -ONE, ONE, 2*ONE, 16'd4, 1'b0));
        send_box(make_box(-ONE, -ONE, 5*ONE, ONE, ONE, 4*ONE, 16'd5, 1'b0));
        send_box(make_box(-ONE, -ONE, -3*ONE, ONE, ONE, -2*ONE, 16'd6, 1'b0));
        send_box(make_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
                          COORD_TOP, COORD_TOP, COORD_TOP, 16'd0, 1'b1));
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 16'd7, 1'b1));
        send_box(make_box(2*ONE, 2*ONE, 2*ONE, 3*ONE, 3*ONE, 3*ONE, 16'd8, 1'b1));
        close_phase();

        // x right at the parallel threshold, y just below it, z reversed
        write_reg(rbnh_pkg::REG_DIR_X, 32'd7);
        write_reg(rbnh_pkg::REG_DIR_Y, 32'd6);
        write_reg(rbnh_pkg::REG_DIR_Z, 32'(-65536));
        send_box(make_box(ONE, -ONE, COORD_BOTTOM, COORD_TOP, ONE, COORD_TOP, 16'h00F0, 1'b0));
        send_box(make_box(COORD_BOTTOM, -ONE, COORD_BOTTOM, -ONE, ONE, COORD_TOP,
                          16'h0F00, 1'b0));
        send_box(make_box(-ONE, -ONE, -3*ONE, ONE, ONE, -2*ONE, 16'h5555, 1'b1));
        close_phase();

        // extreme origin and out-of-range directions
        write_reg(rbnh_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
        write_reg(rbnh_pkg::REG_ORIGIN_Y, 32'h8000_0000);
        write_reg(rbnh_pkg::REG_ORIGIN_Z, 32'h7FFF_FFFF);
        write_reg(rbnh_pkg::REG_DIR_X, 32'h0001_FFFF);
        write_reg(rbnh_pkg::REG_DIR_Y, 32'h0002_0000);
        write_reg(rbnh_pkg::REG_DIR_Z, 32'h0001_0000);
        send_box(make_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
                          COORD_TOP, COORD_TOP, COORD_TOP, 16'hAAAA, 1'b0));
        send_box(make_box(0, 0, 0, 0, 0, 0, 16'h1234, 1'b0));
        send_box(noise_box());
        send_box(make_box(COORD_TOP, COORD_BOTTOM, COORD_TOP,
                          COORD_TOP, COORD_BOTTOM, COORD_TOP, 16'h8001, 1'b1));
        close_phase();

        while (random_sent < RANDOM_BOXES) begin
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
            write_reg(rbnh_pkg::REG_ORIGIN_X, pick_origin());
            write_reg(rbnh_pkg::REG_ORIGIN_Y, pick_origin());
            write_reg(rbnh_pkg::REG_ORIGIN_Z, pick_origin());
            write_reg(rbnh_pkg::REG_DIR_X, pick_dir());
            write_reg(rbnh_pkg::REG_DIR_Y, pick_dir());
            write_reg(rbnh_pkg::REG_DIR_Z, pick_dir());
            n = $urandom_range(10, 40);
            if (n > RANDOM_BOXES - random_sent) n = RANDOM_BOXES - random_sent;
            repeat (n) begin
                if ($urandom_range(0, 4) != 0) send_box(aimed_box());
                else send_box(noise_box());
                random_sent++;
            end
            close_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (hits.failures == 0 && hits.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
